/* src/stereo_feedback_delay_unit_assert.svh */
// Assertion macros shared by the stereo feedback delay unit modules.
`ifndef STEREO_FEEDBACK_DELAY_UNIT_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_IMPL(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sfd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("sfd next-cycle check failed");

`endif

/* src/sfd_pkg.sv */
// Shared constants, register codes and configuration type of the delay unit.
package sfd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 18;
	localparam int DLY_W       = 18;
	localparam int GAIN_W      = 16;
	localparam int MIX_W       = 17;

	localparam logic [GAIN_W-1:0] FB_MAX    = 16'd62259;
	localparam logic [MIX_W-1:0]  MIX_ONE   = 17'd65536;
	localparam logic [DLY_W-1:0]  DLY_RESET = 18'd12000;
	localparam logic [MIX_W-1:0]  MIX_RESET = 17'd32768;

	// Q16 rounding: add one half, then floor-shift.
	localparam int ROUND_HALF  = 32768;
	localparam int ROUND_SHIFT = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_DELAY    = 3'd1,
		REG_FEEDBACK = 3'd2,
		REG_MIX      = 3'd3,
		REG_STEREO   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              enable;
		logic [DLY_W-1:0]  delay;
		logic [GAIN_W-1:0] feedback;
		logic [MIX_W-1:0]  mix;
		logic              stereo;
	} cfg_t;

endpackage

/* src/sfd_if.sv */
// Channel interfaces of the delay unit: dry frames, mixed frames, register writes.
interface sfd_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source(output valid, left_in, right_in, input ready);
	modport sink(input valid, left_in, right_in, output ready);
endinterface

interface sfd_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source(output valid, left_out, right_out, input ready);
	modport sink(input valid, left_out, right_out, output ready);
endinterface

interface sfd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sfd_pkg::CFG_INDEX_W-1:0]  index;
	logic [sfd_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/sfd_front.sv */
// Front end: accepts dry frames, classifies them and prepares addresses and dry products.
`include "stereo_feedback_delay_unit_assert.svh"

module sfd_front #(
	parameter int DELAY_DEPTH = 262144,
	parameter int SAMPLE_BITS = 24,
	parameter type item_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sfd_pkg::cfg_t cfg,
	sfd_in_if.sink        dry,
	output logic          push_valid,
	input  logic          push_ready,
	output item_t         push_item
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = ((AW > sfd_pkg::DLY_W) ? AW : sfd_pkg::DLY_W) + 1;
	localparam int PW = SAMPLE_BITS + 18;
	localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
	localparam logic [CW-1:0] D_MAX   = CW'(DELAY_DEPTH - 1);
	localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);

	logic [AW-1:0]                   wp_q;
	logic                            wrapped_q;
	logic [CW-1:0]                   d_raw;
	logic [CW-1:0]                   d_clamped;
	logic [CW-1:0]                   wp_ext;
	logic [CW-1:0]                   rd_ext;
	logic [sfd_pkg::GAIN_W-1:0]      fb_c;
	logic [sfd_pkg::MIX_W-1:0]       mix_c;
	logic [sfd_pkg::MIX_W-1:0]       mix_inv;
	logic signed [SAMPLE_BITS-1:0]   dry_r;
	logic signed [PW-1:0]            inv_x;
	logic                            accept;
	item_t                           item;

	assign accept     = dry.valid && push_ready;
	assign dry.ready  = push_ready;
	assign push_valid = dry.valid;
	assign push_item  = item;

	always_comb begin
		d_raw = CW'(cfg.delay);
		if (d_raw == '0) begin
			d_clamped = CW'(1);
		end else if (d_raw > D_MAX) begin
			d_clamped = D_MAX;
		end else begin
			d_clamped = d_raw;
		end
		wp_ext = CW'(wp_q);
		rd_ext = (wp_ext >= d_clamped) ? (wp_ext - d_clamped) : (wp_ext + DEPTH_C - d_clamped);

		fb_c    = (cfg.feedback > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX : cfg.feedback;
		mix_c   = (cfg.mix > sfd_pkg::MIX_ONE) ? sfd_pkg::MIX_ONE : cfg.mix;
		mix_inv = sfd_pkg::MIX_ONE - mix_c;
		inv_x   = PW'($signed({1'b0, mix_inv}));

		// Mono copies left into the right dry path, but a bypassed frame passes raw.
		dry_r = (cfg.enable && !cfg.stereo) ? dry.left_in : dry.right_in;

		item.bypass = !cfg.enable;
		// Entries are written in address order from zero, so the read slot has
		// been written once the pointer has wrapped or has passed it.
		item.rd_valid = wrapped_q || (wp_ext >= d_clamped);
		item.wp       = wp_q;
		item.rd       = rd_ext[AW-1:0];
		item.fb       = fb_c;
		item.mix      = mix_c;
		item.dry_l    = dry.left_in;
		item.dry_r    = dry_r;
		item.pre_l    = PW'(dry.left_in) * inv_x;
		item.pre_r    = PW'(dry_r) * inv_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (accept && cfg.enable) begin
			if (wp_q == WP_LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	`SFD_ASSERT_NEXT(a_wp_step, clk, arst_n, accept && cfg.enable, (wp_q == '0) || (wp_q == $past(wp_q) + 1'b1))
	`SFD_ASSERT_NEXT(a_wrap_sticky, clk, arst_n, wrapped_q, wrapped_q)
	`SFD_ASSERT_IMPL(a_rd_not_wp, clk, arst_n, dry.valid && cfg.enable, item.rd != wp_q)

endmodule

/* src/sfd_queue.sv */
// Short FIFO between the front end and the memory back end.
module sfd_queue #(
	parameter int DEPTH = 2,
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/sfd_back.sv */
// Back end: ring memories, feedback and mix arithmetic, and the output register.
`include "stereo_feedback_delay_unit_assert.svh"

module sfd_back #(
	parameter int DELAY_DEPTH = 262144,
	parameter int SAMPLE_BITS = 24,
	parameter type item_t = logic
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	output logic     head_pop,
	input  item_t    head,
	sfd_out_if.source mixed
);

	localparam int AW   = $clog2(DELAY_DEPTH);
	localparam int SW   = SAMPLE_BITS;
	localparam int FW   = SW + 17;
	localparam int PW   = SW + 18;
	localparam int SUMW = SW + 19;
	localparam int XW   = SW + 3;

	typedef enum logic {ST_READ, ST_WRITE} state_t;

	state_t               state_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_l_q;
	logic signed [SW-1:0] out_r_q;
	logic signed [SW-1:0] mem_l [DELAY_DEPTH];
	logic signed [SW-1:0] mem_r [DELAY_DEPTH];
	logic signed [SW-1:0] rdat_l_q;
	logic signed [SW-1:0] rdat_r_q;
	logic [AW-1:0]        mem_addr;
	logic                 mem_re;
	logic                 mem_we;
	logic                 out_free;
	logic signed [SW-1:0] wet_l;
	logic signed [SW-1:0] wet_r;
	logic signed [FW-1:0] fb_x;
	logic signed [FW-1:0] fbp_l;
	logic signed [FW-1:0] fbp_r;
	logic signed [XW-1:0] st_wide_l;
	logic signed [XW-1:0] st_wide_r;
	logic signed [SW-1:0] st_l;
	logic signed [SW-1:0] st_r;
	logic signed [PW-1:0] mix_x;
	logic signed [SUMW-1:0] sum_l;
	logic signed [SUMW-1:0] sum_r;
	logic signed [SW-1:0] o_l;
	logic signed [SW-1:0] o_r;

	function automatic logic signed [SW-1:0] sat(input logic signed [XW-1:0] v);
		logic [3:0] msb4;
		msb4 = v[XW-1:SW-1];
		if (msb4 == 4'b0000 || msb4 == 4'b1111) begin
			sat = v[SW-1:0];
		end else if (v[XW-1]) begin
			sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SW-1){1'b1}}};
		end
	endfunction

	assign out_free = !out_valid_q || mixed.ready;
	assign mem_re   = (state_q == ST_READ) && head_valid && !head.bypass;
	assign mem_we   = (state_q == ST_WRITE) && out_free;
	assign mem_addr = mem_we ? head.wp : head.rd;
	assign head_pop = ((state_q == ST_READ) && head_valid && head.bypass && out_free) || mem_we;

	assign mixed.valid     = out_valid_q;
	assign mixed.left_out  = out_l_q;
	assign mixed.right_out = out_r_q;

	always_comb begin
		// Slots not yet written since reset read as silence.
		wet_l = head.rd_valid ? rdat_l_q : '0;
		wet_r = head.rd_valid ? rdat_r_q : '0;

		fb_x  = FW'($signed({1'b0, head.fb}));
		fbp_l = (FW'(wet_l) * fb_x) + $signed(FW'(sfd_pkg::ROUND_HALF));
		fbp_r = (FW'(wet_r) * fb_x) + $signed(FW'(sfd_pkg::ROUND_HALF));
		st_wide_l = XW'(fbp_l >>> sfd_pkg::ROUND_SHIFT) + XW'(head.dry_l);
		st_wide_r = XW'(fbp_r >>> sfd_pkg::ROUND_SHIFT) + XW'(head.dry_r);
		st_l = sat(st_wide_l);
		st_r = sat(st_wide_r);

		mix_x = PW'($signed({1'b0, head.mix}));
		sum_l = SUMW'(head.pre_l) + SUMW'(PW'(wet_l) * mix_x)
			+ $signed(SUMW'(sfd_pkg::ROUND_HALF));
		sum_r = SUMW'(head.pre_r) + SUMW'(PW'(wet_r) * mix_x)
			+ $signed(SUMW'(sfd_pkg::ROUND_HALF));
		o_l = sat(XW'(sum_l >>> sfd_pkg::ROUND_SHIFT));
		o_r = sat(XW'(sum_r >>> sfd_pkg::ROUND_SHIFT));
	end

	// One port per store: read in the read state of a frame, write in the write state that follows.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_l[mem_addr] <= st_l;
			mem_r[mem_addr] <= st_r;
		end else if (mem_re) begin
			rdat_l_q <= mem_l[mem_addr];
			rdat_r_q <= mem_r[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READ;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
		end else begin
			// Every item that leaves the queue lands in the output register.
			if (head_pop) begin
				out_valid_q <= 1'b1;
			end else if (mixed.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_READ: begin
					if (head_valid) begin
						if (head.bypass) begin
							if (out_free) begin
								out_l_q <= head.dry_l;
								out_r_q <= head.dry_r;
							end
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						out_l_q <= o_l;
						out_r_q <= o_r;
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_READ;
				end
			endcase
		end
	end

	`SFD_ASSERT_NEXT(a_hold_read, clk, arst_n, (state_q == ST_WRITE) && !out_free,
		$stable(rdat_l_q) && $stable(rdat_r_q))
	`SFD_ASSERT_IMPL(a_write_head, clk, arst_n, state_q == ST_WRITE,
		head_valid && !head.bypass)
	`SFD_ASSERT_IMPL(a_single_port, clk, arst_n, mem_we, !mem_re)

endmodule

/* src/stereo_feedback_delay_unit.sv */
// Top level of the stereo feedback delay unit: configuration registers and unit wiring.
//
// Channels: dry takes one stereo frame (left_in, right_in) per item, mixed returns one
// mixed frame (left_out, right_out) per item, both valid/ready; cfg writes register
// index/data and is always ready (0 enable, 1 delay, 2 feedback, 3 mix, 4 stereo).
// Registers should only be written while no frame is in flight.
// A two-entry queue sits between the front end and the memory back end, so new frames
// are taken while earlier ones are still being processed or waiting at the output.
// A processed frame passes the queue, the back end's read state and its write state before
// it lands in the output register on mixed; a bypassed frame (enable low) goes from the
// queue straight into the output register. The single port of each ring memory (read of
// the delayed sample, then write of the new one) keeps the back end from taking another
// frame until the write is done; bypassed frames go one per cycle while mixed is ready.
// Reset clears the write pointer, queue, output register and configuration to its
// defaults. The ring memories are not swept: slots never written since reset read as
// zero, tracked by the write pointer and a wrap flag, so frames are taken right away.
// When mixed stalls, the output register holds, the back end waits and the queue fills;
// dry then drops ready until space frees up.
module stereo_feedback_delay_unit #(
	parameter int DELAY_DEPTH = 262144,
	parameter int SAMPLE_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	sfd_in_if.sink    dry,
	sfd_out_if.source mixed,
	sfd_cfg_if.sink   cfg
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int PW = SAMPLE_BITS + 18;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic                         bypass;
		logic                         rd_valid;
		logic [AW-1:0]                wp;
		logic [AW-1:0]                rd;
		logic [sfd_pkg::GAIN_W-1:0]   fb;
		logic [sfd_pkg::MIX_W-1:0]    mix;
		logic signed [SAMPLE_BITS-1:0] dry_l;
		logic signed [SAMPLE_BITS-1:0] dry_r;
		logic signed [PW-1:0]         pre_l;
		logic signed [PW-1:0]         pre_r;
	} item_t;

	sfd_pkg::cfg_t cfg_q;
	logic          push_valid;
	logic          push_ready;
	item_t         push_item;
	logic          head_valid;
	logic          head_pop;
	item_t         head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b0;
			cfg_q.delay    <= sfd_pkg::DLY_RESET;
			cfg_q.feedback <= '0;
			cfg_q.mix      <= sfd_pkg::MIX_RESET;
			cfg_q.stereo   <= 1'b1;
		end else if (cfg.valid) begin
			case (sfd_pkg::cfg_reg_t'(cfg.index))
				sfd_pkg::REG_ENABLE:   cfg_q.enable   <= cfg.data[0];
				sfd_pkg::REG_DELAY:    cfg_q.delay    <= cfg.data[sfd_pkg::DLY_W-1:0];
				sfd_pkg::REG_FEEDBACK: cfg_q.feedback <= cfg.data[sfd_pkg::GAIN_W-1:0];
				sfd_pkg::REG_MIX:      cfg_q.mix      <= cfg.data[sfd_pkg::MIX_W-1:0];
				sfd_pkg::REG_STEREO:   cfg_q.stereo   <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	sfd_front #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.item_t     (item_t)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.dry       (dry),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	sfd_queue #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(item_t)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (head_valid),
		.pop_ready (head_pop),
		.pop_item  (head)
	);

	sfd_back #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.item_t     (item_t)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_pop  (head_pop),
		.head      (head),
		.mixed     (mixed)
	);

endmodule

/* verif/tb_stereo_feedback_delay_unit.sv */
// Self-checking testbench of the stereo feedback delay unit: table-driven and random frames.
module tb_stereo_feedback_delay_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = 262144;
	localparam int SB             = 24;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int LONG_HOLD      = 600;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [sfd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [sfd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [SB-1:0] left;
		logic [SB-1:0] right;
	} frame_t;

	typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

	// A write row carries index and data; a frame row carries left and right samples.
	typedef struct packed {
		row_kind_t     kind;
		logic [23:0]   a;
		logic [23:0]   b;
		logic          pinned;
		logic [SB-1:0] want_left;
		logic [SB-1:0] want_right;
	} plan_row_t;

	localparam int PLAN_ROWS = 37;

	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_FRAME, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
		'{ROW_FRAME, 24'h800000, 24'h7FFFFF, 1'b1, 24'h800000, 24'h7FFFFF},
		'{ROW_FRAME, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 24'hFFFFFF},
		'{ROW_WRITE, 24'(sfd_pkg::REG_STEREO), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h000005, 24'h00007B, 1'b1, 24'h000005, 24'h00007B},
		'{ROW_WRITE, 24'(sfd_pkg::REG_ENABLE), 24'h00001, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_DELAY), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_FEEDBACK), 24'h3FFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_MIX), 24'h3FFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_STEREO), 24'h00001, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h7FFFFF, 24'h800000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h7FFFFF, 24'h800000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h7FFFFF, 24'h800000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h800000, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h800000, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_MIX), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h123456, 24'h800000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_MIX), 24'(sfd_pkg::MIX_ONE), 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h000001, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_MIX), 24'(sfd_pkg::MIX_RESET), 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_FEEDBACK), 24'(sfd_pkg::FB_MAX), 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h000001, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'hFFFFFF, 24'h000001, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_STEREO), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h0003E8, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'hFFFC18, 24'h800000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_DELAY), 24'h3FFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h400000, 24'hC00000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(REG_UNMAPPED_LO), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(REG_UNMAPPED_HI), 24'h3FFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_DELAY), 24'h00003, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_FEEDBACK), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h2AAAAA, 24'hD55555, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'h555555, 24'hAAAAAA, 1'b0, 24'h0, 24'h0},
		'{ROW_WRITE, 24'(sfd_pkg::REG_ENABLE), 24'h00000, 1'b0, 24'h0, 24'h0},
		'{ROW_FRAME, 24'hABCDEF, 24'h123456, 1'b1, 24'hABCDEF, 24'h123456}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sfd_in_if  #(.SAMPLE_BITS(SB)) dry_ch();
	sfd_out_if #(.SAMPLE_BITS(SB)) mixed_ch();
	sfd_cfg_if                     cfg_ch();

	stereo_feedback_delay_unit #(
		.DELAY_DEPTH(DEPTH),
		.SAMPLE_BITS(SB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.dry(dry_ch),
		.mixed(mixed_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block: registers, ring stores and write pointer.
	sfd_pkg::cfg_t regs;
	logic [SB-1:0] left_ring  [DEPTH];
	logic [SB-1:0] right_ring [DEPTH];
	int            wr_ptr;

	frame_t mixed_frames_due [$];
	frame_t want;
	frame_t pin_frame;
	bit     pin_next;
	int     fail_count;
	bit     rx_steady;
	bit     hold_off_request;

	function automatic longint round_q16(input longint p);
		return (p + sfd_pkg::ROUND_HALF) >>> sfd_pkg::ROUND_SHIFT;
	endfunction

	function automatic logic [SB-1:0] clip(input longint v);
		longint top;
		longint bottom;
		top    = (longint'(1) <<< (SB - 1)) - 1;
		bottom = -top - 1;
		if (v > top)
			return top[SB-1:0];
		if (v < bottom)
			return bottom[SB-1:0];
		return v[SB-1:0];
	endfunction

	// Works out the mixed frame for one dry frame and advances the mirrored state.
	function automatic frame_t echo_frame(input logic signed [SB-1:0] l_in,
			input logic signed [SB-1:0] r_in);
		frame_t               res;
		logic signed [SB-1:0] dry_l;
		logic signed [SB-1:0] dry_r;
		logic signed [SB-1:0] wet_l;
		logic signed [SB-1:0] wet_r;
		int                   d;
		int                   rd;
		longint               fb;
		longint               mx;
		if (!regs.enable) begin
			res.left  = l_in;
			res.right = r_in;
			return res;
		end
		dry_l = l_in;
		dry_r = regs.stereo ? r_in : l_in;
		d = int'(regs.delay);
		if (d < 1)
			d = 1;
		if (d > DEPTH - 1)
			d = DEPTH - 1;
		fb = (regs.feedback > sfd_pkg::FB_MAX) ? longint'(sfd_pkg::FB_MAX)
			: longint'(regs.feedback);
		mx = (regs.mix > sfd_pkg::MIX_ONE) ? longint'(sfd_pkg::MIX_ONE) : longint'(regs.mix);
		rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + DEPTH - d;
		wet_l = left_ring[rd];
		wet_r = right_ring[rd];
		left_ring[wr_ptr]  = clip(longint'(dry_l) + round_q16(longint'(wet_l) * fb));
		right_ring[wr_ptr] = clip(longint'(dry_r) + round_q16(longint'(wet_r) * fb));
		res.left  = clip(round_q16(longint'(dry_l) * (longint'(sfd_pkg::MIX_ONE) - mx)
			+ longint'(wet_l) * mx));
		res.right = clip(round_q16(longint'(dry_r) * (longint'(sfd_pkg::MIX_ONE) - mx)
			+ longint'(wet_r) * mx));
		wr_ptr = (wr_ptr + 1) % DEPTH;
		return res;
	endfunction

	function automatic logic [SB-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0: return {1'b0, {(SB - 1){1'b1}}};
			1: return {1'b1, {(SB - 1){1'b0}}};
			2: begin
				v = $urandom_range(0, 64);
				return SB'(v - 32);
			end
			default: return SB'($urandom);
		endcase
	endfunction

	// Tasks below are entered and left just after a falling edge.
	task automatic send_frame(input logic [SB-1:0] l, input logic [SB-1:0] r,
			input bit pinned, input frame_t pinned_value);
		dry_ch.valid    <= 1'b1;
		dry_ch.left_in  <= l;
		dry_ch.right_in <= r;
		pin_next  = pinned;
		pin_frame = pinned_value;
		do
			@(posedge clk);
		while (dry_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic idle_dry(input int cycles);
		dry_ch.valid    <= 1'b0;
		dry_ch.left_in  <= SB'($urandom);
		dry_ch.right_in <= SB'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_mixed();
		dry_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (mixed_frames_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sfd_pkg::CFG_DATA_W-1:0] val);
		drain_mixed();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (sfd_pkg::cfg_reg_t'(cfg_ch.index))
					sfd_pkg::REG_ENABLE:   regs.enable   = cfg_ch.data[0];
					sfd_pkg::REG_DELAY:    regs.delay    = cfg_ch.data[sfd_pkg::DLY_W-1:0];
					sfd_pkg::REG_FEEDBACK: regs.feedback = cfg_ch.data[sfd_pkg::GAIN_W-1:0];
					sfd_pkg::REG_MIX:      regs.mix      = cfg_ch.data[sfd_pkg::MIX_W-1:0];
					sfd_pkg::REG_STEREO:   regs.stereo   = cfg_ch.data[0];
					default:      ;
				endcase
			end
			if (mixed_ch.valid && mixed_ch.ready) begin
				if (mixed_frames_due.size() == 0) begin
					$error("mixed item with none expected: left_out %0d, right_out %0d",
						$signed(mixed_ch.left_out), $signed(mixed_ch.right_out));
					fail_count++;
				end else begin
					want = mixed_frames_due.pop_front();
					if (mixed_ch.left_out !== want.left) begin
						$error("left_out mismatch: expected %0d, actual %0d",
							$signed(want.left), $signed(mixed_ch.left_out));
						fail_count++;
					end
					if (mixed_ch.right_out !== want.right) begin
						$error("right_out mismatch: expected %0d, actual %0d",
							$signed(want.right), $signed(mixed_ch.right_out));
						fail_count++;
					end
				end
			end
			if (dry_ch.valid && dry_ch.ready) begin
				want = echo_frame(dry_ch.left_in, dry_ch.right_in);
				if (pin_next)
					want = pin_frame;
				mixed_frames_due = {mixed_frames_due, want};
			end
		end
	end

	// Receiver: random runs of ready and stall, or always ready, plus one long hold-off.
	initial begin
		int run_len;
		bit run_high;
		run_len  = 0;
		run_high = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				mixed_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (rx_steady) begin
				mixed_ch.ready <= 1'b1;
			end else begin
				if (run_len == 0) begin
					run_high = !run_high;
					run_len  = run_high ? $urandom_range(1, 12) : $urandom_range(1, 8);
				end
				mixed_ch.ready <= run_high;
				run_len--;
			end
		end
	end

	// Watchdog: ends the run when no channel has moved an item for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((dry_ch.valid && dry_ch.ready) || (mixed_ch.valid && mixed_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		frame_t blank;
		int     sent;
		int     phase;
		int     phase_items;
		int     burst_left;
		bit     tx_bursty;
		blank            = '0;
		fail_count       = 0;
		pin_next         = 1'b0;
		pin_frame        = '0;
		rx_steady        = 1'b1;
		hold_off_request = 1'b0;
		dry_ch.valid     = 1'b0;
		dry_ch.left_in   = '0;
		dry_ch.right_in  = '0;
		mixed_ch.ready   = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		regs = '{enable: 1'b0, delay: sfd_pkg::DLY_RESET, feedback: '0,
			mix: sfd_pkg::MIX_RESET, stereo: 1'b1};
		wr_ptr = 0;
		foreach (left_ring[i]) begin
			left_ring[i]  = '0;
			right_ring[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].a[sfd_pkg::CFG_INDEX_W-1:0],
					plan[i].b[sfd_pkg::CFG_DATA_W-1:0]);
			else
				send_frame(plan[i].a, plan[i].b, plan[i].pinned,
					'{left: plan[i].want_left, right: plan[i].want_right});
		end

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			tx_bursty = (phase != 0) && ($urandom_range(0, 3) != 0);
			rx_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(sfd_pkg::REG_ENABLE,
					sfd_pkg::CFG_DATA_W'((phase == 2) || ($urandom_range(0, 9) != 0)));
			if ($urandom_range(0, 3) != 0) begin
				// Short delays keep the feedback path busy; long ones read untouched slots.
				case ($urandom_range(0, 9))
					0:       write_reg(sfd_pkg::REG_DELAY, '0);
					1:       write_reg(sfd_pkg::REG_DELAY, '1);
					2:       write_reg(sfd_pkg::REG_DELAY,
						sfd_pkg::CFG_DATA_W'($urandom_range(1, 4000)));
					default: write_reg(sfd_pkg::REG_DELAY,
						sfd_pkg::CFG_DATA_W'($urandom_range(1, 40)));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       write_reg(sfd_pkg::REG_FEEDBACK, '0);
					1:       write_reg(sfd_pkg::REG_FEEDBACK,
						sfd_pkg::CFG_DATA_W'(sfd_pkg::FB_MAX));
					2:       write_reg(sfd_pkg::REG_FEEDBACK,
						sfd_pkg::CFG_DATA_W'($urandom));
					3:       write_reg(sfd_pkg::REG_FEEDBACK,
						sfd_pkg::CFG_DATA_W'($urandom_range(int'(sfd_pkg::FB_MAX) + 1, 65535)));
					default: write_reg(sfd_pkg::REG_FEEDBACK,
						sfd_pkg::CFG_DATA_W'($urandom_range(0, sfd_pkg::FB_MAX)));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       write_reg(sfd_pkg::REG_MIX, '0);
					1:       write_reg(sfd_pkg::REG_MIX,
						sfd_pkg::CFG_DATA_W'(sfd_pkg::MIX_ONE));
					2:       write_reg(sfd_pkg::REG_MIX,
						sfd_pkg::CFG_DATA_W'($urandom_range(int'(sfd_pkg::MIX_ONE) + 1, 131071)));
					3:       write_reg(sfd_pkg::REG_MIX, sfd_pkg::CFG_DATA_W'($urandom));
					default: write_reg(sfd_pkg::REG_MIX,
						sfd_pkg::CFG_DATA_W'($urandom_range(0, sfd_pkg::MIX_ONE)));
				endcase
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(sfd_pkg::REG_STEREO,
					sfd_pkg::CFG_DATA_W'($urandom_range(0, 2) != 0));
			if ($urandom_range(0, 3) == 0)
				write_reg(sfd_pkg::CFG_INDEX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
					sfd_pkg::CFG_DATA_W'($urandom));

			// One phase holds the receiver off while frames keep coming, to fill the block.
			if (phase == 2) begin
				tx_bursty        = 1'b0;
				hold_off_request = 1'b1;
			end
			phase_items = $urandom_range(60, 190);
			burst_left  = $urandom_range(1, 20);
			for (int k = 0; k < phase_items; k++) begin
				if (phase == 4 && k == phase_items / 2) begin
					drain_mixed();
				end else if (tx_bursty && burst_left == 0) begin
					idle_dry($urandom_range(1, 15));
					burst_left = $urandom_range(1, 20);
				end
				send_frame(pick_sample(), pick_sample(), 1'b0, blank);
				if (burst_left > 0)
					burst_left--;
			end
			sent += phase_items;
			phase++;
		end

		drain_mixed();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
